>>> hw/rtl/glob_to_regex_translator_macros.svh
// Assertion macros for the translator RTL.
`ifndef GLOB_TO_REGEX_TRANSLATOR_MACROS_SVH
`define GLOB_TO_REGEX_TRANSLATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is held
`define G2R_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds through reset
`define G2R_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define G2R_ASSERT(lbl, clk, rst_n, prop, msg)
`define G2R_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hw/rtl/g2r_pkg.sv
package g2r_pkg;

    // Translator mode
    typedef enum logic [2:0] {
        MODE_NORMAL    = 3'd0,
        MODE_ESCAPE    = 3'd1,
        MODE_SET_FIRST = 3'd2,
        MODE_SET_BODY  = 3'd3,
        MODE_ERROR     = 3'd4
    } t_mode;

    // Pattern status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EMPTY_SET = 2'd1;
    localparam t_status ST_NO_CLOSE  = 2'd2;
    localparam t_status ST_BAD_ESC   = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Emitted count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // One translated word plus the state it leaves behind
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        t_status    status;
        t_mode      mode_nx;
        t_status    err_nx;
    } t_xlate_res;

    // Regex metacharacters that need a backslash
    function automatic logic is_meta(input logic [7:0] b);
        is_meta = (b == CH_PLUS)   || (b == CH_DOT)    || (b == CH_LPAREN) ||
                  (b == CH_RPAREN) || (b == CH_LBRACE) || (b == CH_RBRACE) ||
                  (b == CH_CARET)  || (b == CH_DOLLAR);
    endfunction

endpackage

>>> hw/rtl/g2r_xlate.sv
module g2r_xlate
    import g2r_pkg::*;
(
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  t_mode      i_mode,
    input  t_status    i_err,
    output t_xlate_res o_res
);

    logic [1:0] cnt;
    logic [7:0] e0;
    logic [7:0] e1;
    t_mode      mode_nx;
    t_status    err_nx;

    // Per-mode translation of one pattern byte
    always_comb begin
        cnt     = CNT_NONE;
        e0      = 8'h00;
        e1      = 8'h00;
        mode_nx = i_mode;
        err_nx  = i_err;
        unique case (i_mode)
            MODE_NORMAL: begin
                if (i_byte == CH_STAR) begin
                    e0  = CH_DOT;
                    e1  = CH_STAR;
                    cnt = CNT_TWO;
                end else if (i_byte == CH_QUEST) begin
                    e0  = CH_DOT;
                    cnt = CNT_ONE;
                end else if (i_byte == CH_LBRACK) begin
                    e0      = CH_LBRACK;
                    cnt     = CNT_ONE;
                    mode_nx = MODE_SET_FIRST;
                end else if (i_byte == CH_BSLASH) begin
                    mode_nx = MODE_ESCAPE;
                end else if (is_meta(i_byte)) begin
                    e0  = CH_BSLASH;
                    e1  = i_byte;
                    cnt = CNT_TWO;
                end else begin
                    e0  = i_byte;
                    cnt = CNT_ONE;
                end
            end
            MODE_ESCAPE: begin
                e0      = i_byte;
                cnt     = CNT_ONE;
                mode_nx = MODE_NORMAL;
            end
            MODE_SET_FIRST: begin
                if (i_byte == CH_BANG) begin
                    e0      = CH_CARET;
                    cnt     = CNT_ONE;
                    mode_nx = MODE_SET_BODY;
                end else if (i_byte == CH_RBRACK) begin
                    err_nx  = ST_EMPTY_SET;
                    mode_nx = MODE_ERROR;
                end else begin
                    e0      = i_byte;
                    cnt     = CNT_ONE;
                    mode_nx = MODE_SET_BODY;
                end
            end
            MODE_SET_BODY: begin
                e0  = i_byte;
                cnt = CNT_ONE;
                if (i_byte == CH_RBRACK) begin
                    mode_nx = MODE_NORMAL;
                end
            end
            default: begin
                // error mode and unused codes stay silent
            end
        endcase

        // End of pattern: dangling escape or open set
        if (i_last && (err_nx == ST_OK)) begin
            if (mode_nx == MODE_ESCAPE) begin
                err_nx = ST_BAD_ESC;
                cnt    = CNT_NONE;
                e0     = 8'h00;
                e1     = 8'h00;
            end else if ((mode_nx == MODE_SET_FIRST) || (mode_nx == MODE_SET_BODY)) begin
                err_nx = ST_NO_CLOSE;
                cnt    = CNT_NONE;
                e0     = 8'h00;
                e1     = 8'h00;
            end
        end
    end

    // Result word and state for the next byte
    always_comb begin
        o_res.count       = cnt;
        o_res.first_byte  = e0;
        o_res.second_byte = e1;
        o_res.status      = err_nx;
        o_res.mode_nx     = i_last ? MODE_NORMAL : mode_nx;
        o_res.err_nx      = i_last ? ST_OK : err_nx;
    end

endmodule

>>> hw/rtl/glob_to_regex_translator.sv
// Glob-to-regex translator. Takes one wildcard pattern byte per word on the
// slave stream (tlast marks the pattern's final byte) and returns exactly one
// result word per input word on the master stream: up to two regex bytes, a
// count, and the sticky status (0 ok, 1 empty set, 2 missing ']', 3 bad
// escape) in tuser; tlast repeats the end-of-pattern flag. The status on the
// tlast word decides whether the pattern's output is usable. Throughput is one
// byte per clock while the receiver keeps tready high; each byte passes the input
// register, the single translate stage and the result register. Mode and status
// return to their reset values after each pattern's last byte.
`include "glob_to_regex_translator_macros.svh"

module glob_to_regex_translator
    import g2r_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pattern_byte
    input  logic        s_axis_tlast,   // end_of_pattern
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [1:0] byte_count, [9:2] first_byte,
                                        // [17:10] second_byte, [23:18] zero
    output logic        m_axis_tlast,   // pattern_done
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_mode      r_mode;
    t_status    r_err;
    logic       r_out_valid;
    logic [1:0] r_out_count;
    logic [7:0] r_out_first;
    logic [7:0] r_out_second;
    t_status    r_out_status;
    logic       r_out_last;
    t_xlate_res w_res;
    logic       w_out_adv;
    logic       w_in_move;

    // Pipeline flow control
    assign w_out_adv     = !r_out_valid || m_axis_tready;
    assign w_in_move     = r_in_valid && w_out_adv;
    assign s_axis_tready = !r_in_valid || w_out_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Translate stage
    g2r_xlate u_xlate (
        .i_byte (r_in_byte),
        .i_last (r_in_last),
        .i_mode (r_mode),
        .i_err  (r_err),
        .o_res  (w_res)
    );

    // Mode and sticky status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_err  <= ST_OK;
        end else if (w_in_move) begin
            r_mode <= w_res.mode_nx;
            r_err  <= w_res.err_nx;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_move) begin
            r_out_count  <= w_res.count;
            r_out_first  <= w_res.first_byte;
            r_out_second <= w_res.second_byte;
            r_out_status <= w_res.status;
            r_out_last   <= r_in_last;
        end
    end

    // Output packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_second, r_out_first, r_out_count};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_status;

    // Checks
    `G2R_ASSERT(a_err_only_in_error_mode, i_clk, i_rst_n, (r_err != ST_OK) |-> (r_mode == MODE_ERROR), "sticky error outside error mode")
    `G2R_ASSERT(a_state_clears_at_end, i_clk, i_rst_n, (w_in_move && r_in_last) |=> ((r_mode == MODE_NORMAL) && (r_err == ST_OK)), "state not cleared after last byte")
    `G2R_ASSERT(a_count_range, i_clk, i_rst_n, m_axis_tvalid |-> ((m_axis_tdata[1:0] != 2'd3) && ((m_axis_tdata[1:0] != CNT_NONE) || (m_axis_tdata[9:2] == 8'h00))), "bad count or stray byte")
    `G2R_ASSERT(a_stall_backpressure, i_clk, i_rst_n, (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready, "input taken while pipeline full")
    `G2R_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> (!r_in_valid && !r_out_valid), "pipeline not empty after reset")

endmodule

>>> sim/glob_to_regex_translator_checker.sv
module glob_to_regex_translator_checker
    import g2r_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] pattern_byte
    input  logic        i_s_tlast,      // end_of_pattern
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,      // [1:0] byte_count, [9:2] first_byte,
                                        // [17:10] second_byte, [23:18] zero
    input  logic        i_m_tlast,      // pattern_done
    input  logic [1:0]  i_m_tuser,      // [1:0] status
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Expected contents of one output word
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       done;
        t_status    status;
    } t_regex_word;

    t_regex_word regex_expect_q[$];
    t_mode       pat_mode;
    t_status     pat_err;
    int          words_seen;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        words_seen   = 0;
        pat_mode     = MODE_NORMAL;
        pat_err      = ST_OK;
    end

    task automatic report_fault(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    // Regex metacharacters that get a backslash in front
    function automatic logic needs_backslash(input logic [7:0] b);
        logic hit;
        case (b)
            CH_PLUS, CH_DOT, CH_LPAREN, CH_RPAREN,
            CH_LBRACE, CH_RBRACE, CH_CARET, CH_DOLLAR: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Translate one pattern byte, advancing pat_mode / pat_err
    function automatic t_regex_word translate_byte(input logic [7:0] b, input logic last);
        t_regex_word w;
        w = '0;
        w.done = last;
        case (pat_mode)
            MODE_NORMAL: begin
                if (b == CH_STAR) begin
                    w.count = CNT_TWO; w.first_byte = CH_DOT; w.second_byte = CH_STAR;
                end else if (b == CH_QUEST) begin
                    w.count = CNT_ONE; w.first_byte = CH_DOT;
                end else if (b == CH_LBRACK) begin
                    w.count = CNT_ONE; w.first_byte = CH_LBRACK;
                    pat_mode = MODE_SET_FIRST;
                end else if (b == CH_BSLASH) begin
                    pat_mode = MODE_ESCAPE;
                end else if (needs_backslash(b)) begin
                    w.count = CNT_TWO; w.first_byte = CH_BSLASH; w.second_byte = b;
                end else begin
                    w.count = CNT_ONE; w.first_byte = b;
                end
            end
            MODE_ESCAPE: begin
                w.count = CNT_ONE; w.first_byte = b;
                pat_mode = MODE_NORMAL;
            end
            MODE_SET_FIRST: begin
                if (b == CH_BANG) begin
                    w.count = CNT_ONE; w.first_byte = CH_CARET;
                    pat_mode = MODE_SET_BODY;
                end else if (b == CH_RBRACK) begin
                    pat_err  = ST_EMPTY_SET;
                    pat_mode = MODE_ERROR;
                end else begin
                    w.count = CNT_ONE; w.first_byte = b;
                    pat_mode = MODE_SET_BODY;
                end
            end
            MODE_SET_BODY: begin
                w.count = CNT_ONE; w.first_byte = b;
                if (b == CH_RBRACK) pat_mode = MODE_NORMAL;
            end
            default: ;  // error mode stays silent
        endcase

        // Dangling escape or open set at the end of the pattern
        if (last && pat_err == ST_OK) begin
            if (pat_mode == MODE_ESCAPE) begin
                pat_err = ST_BAD_ESC;
                w.count = CNT_NONE;
            end else if (pat_mode == MODE_SET_FIRST || pat_mode == MODE_SET_BODY) begin
                pat_err = ST_NO_CLOSE;
                w.count = CNT_NONE;
            end
        end
        if (w.count == CNT_NONE) begin
            w.first_byte  = '0;
            w.second_byte = '0;
        end
        w.status = pat_err;
        if (last) begin
            pat_mode = MODE_NORMAL;
            pat_err  = ST_OK;
        end
        return w;
    endfunction

    // Predict on accepted input words, compare accepted output words
    always @(posedge i_clk) begin
        t_regex_word want;
        if (!i_rst_n) begin
            pat_mode = MODE_NORMAL;
            pat_err  = ST_OK;
        end else begin
            if (i_s_tvalid && i_s_tready)
                regex_expect_q.push_back(translate_byte(i_s_tdata, i_s_tlast));
            if (i_m_tvalid && i_m_tready) begin
                words_seen++;
                if (regex_expect_q.size() == 0) begin
                    report_fault($sformatf("word %0d arrived with nothing expected",
                                           words_seen));
                end else begin
                    want = regex_expect_q.pop_front();
                    if (i_m_tdata[1:0] !== want.count)
                        report_fault($sformatf("word %0d byte_count %0d, expected %0d",
                                               words_seen, i_m_tdata[1:0], want.count));
                    if (i_m_tdata[9:2] !== want.first_byte)
                        report_fault($sformatf("word %0d first_byte %h, expected %h",
                                               words_seen, i_m_tdata[9:2], want.first_byte));
                    if (i_m_tdata[17:10] !== want.second_byte)
                        report_fault($sformatf("word %0d second_byte %h, expected %h",
                                               words_seen, i_m_tdata[17:10],
                                               want.second_byte));
                    if (i_m_tdata[23:18] !== 6'd0)
                        report_fault($sformatf("word %0d pad bits %h, expected zero",
                                               words_seen, i_m_tdata[23:18]));
                    if (i_m_tlast !== want.done)
                        report_fault($sformatf("word %0d pattern_done %b, expected %b",
                                               words_seen, i_m_tlast, want.done));
                    if (i_m_tuser !== want.status)
                        report_fault($sformatf("word %0d status %0d, expected %0d",
                                               words_seen, i_m_tuser, want.status));
                end
            end
        end
        o_pending <= regex_expect_q.size();
    end

endmodule

>>> sim/glob_to_regex_translator_test.sv
module glob_to_regex_translator_test
    import g2r_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM_BYTES = 1900;
    localparam int CYCLE_LIMIT    = 250000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] pattern_byte
    logic        s_axis_tlast;     // end_of_pattern
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // [1:0] byte_count, [9:2] first_byte,
                                   // [17:10] second_byte, [23:18] zero
    logic        m_axis_tlast;     // pattern_done
    logic [1:0]  m_axis_tuser;     // [1:0] status

    int pending;
    int fail_count;
    int cycle_cnt;
    int bytes_sent;
    int burst_left;
    bit hold_req;

    glob_to_regex_translator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    glob_to_regex_translator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_m_tuser    (m_axis_tuser),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: free-running, random and patterned stalls, plus long holds on request
    initial begin
        int     hold_cnt;
        int     phase_left;
        int     phase_kind;
        logic [7:0] stall_pat;
        hold_cnt   = 0;
        phase_left = 0;
        phase_kind = 0;
        stall_pat  = '0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    phase_kind = $urandom_range(0, 2);
                    phase_left = $urandom_range(8, 64);
                    stall_pat  = 8'($urandom);
                end
                phase_left--;
                case (phase_kind)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        m_axis_tready <= stall_pat[0];
                        stall_pat = {stall_pat[0], stall_pat[7:1]};
                    end
                endcase
            end
        end
    end

    // Offer one word, with bursts and gaps, and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    // Build one random pattern and send it: mostly well formed, some noise
    // and some deliberately broken
    task automatic send_random_pattern();
        logic [7:0] pat[$];
        logic [7:0] metas[8];
        int kind;
        int ntok;
        int nbody;
        logic [7:0] b;
        metas[0] = CH_PLUS;   metas[1] = CH_DOT;    metas[2] = CH_LPAREN;
        metas[3] = CH_RPAREN; metas[4] = CH_LBRACE; metas[5] = CH_RBRACE;
        metas[6] = CH_CARET;  metas[7] = CH_DOLLAR;
        kind = $urandom_range(0, 9);
        ntok = $urandom_range(1, 6);
        if (kind == 8) begin
            // noise: any byte at all
            ntok = $urandom_range(1, 10);
            for (int i = 0; i < ntok; i++) pat.push_back(8'($urandom_range(0, 255)));
        end else begin
            for (int i = 0; i < ntok; i++) begin
                case ($urandom_range(0, 9))
                    0: pat.push_back(CH_STAR);
                    1: pat.push_back(CH_QUEST);
                    2: pat.push_back(metas[3'($urandom_range(0, 7))]);
                    3: begin
                        pat.push_back(CH_BSLASH);
                        pat.push_back(8'($urandom_range(0, 255)));
                    end
                    4, 5: begin
                        pat.push_back(CH_LBRACK);
                        nbody = $urandom_range(0, 4);
                        if ($urandom_range(0, 1)) pat.push_back(CH_BANG);
                        else if (nbody == 0) nbody = 1;
                        for (int j = 0; j < nbody; j++) begin
                            b = 8'($urandom_range(0, 255));
                            pat.push_back((b == CH_RBRACK) ? 8'h61 : b);
                        end
                        pat.push_back(CH_RBRACK);
                    end
                    default: begin
                        b = 8'($urandom_range(0, 255));
                        pat.push_back((b == CH_LBRACK || b == CH_BSLASH) ? 8'h78 : b);
                    end
                endcase
            end
            // broken tail: open set, dangling escape or empty set
            if (kind == 9) begin
                case ($urandom_range(0, 3))
                    0: pat.push_back(CH_LBRACK);
                    1: begin
                        pat.push_back(CH_LBRACK);
                        pat.push_back(8'($urandom_range(0, 255)));
                    end
                    2: pat.push_back(CH_BSLASH);
                    default: begin
                        pat.push_back(CH_LBRACK);
                        pat.push_back(CH_RBRACK);
                        pat.push_back(CH_STAR);
                    end
                endcase
            end
        end
        for (int i = 0; i < pat.size(); i++) send_byte(pat[i], i == pat.size() - 1);
    endtask

    // Stimulus and verdict
    initial begin
        int holds_done;
        holds_done = 0;
        bytes_sent = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // star and question mark
        send_byte(CH_STAR, 1'b0);
        send_byte(CH_QUEST, 1'b1);
        // extreme byte values as literals
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // every metacharacter
        send_byte(CH_PLUS, 1'b0);
        send_byte(CH_DOT, 1'b0);
        send_byte(CH_LPAREN, 1'b0);
        send_byte(CH_RPAREN, 1'b0);
        send_byte(CH_LBRACE, 1'b0);
        send_byte(CH_RBRACE, 1'b0);
        send_byte(CH_CARET, 1'b0);
        send_byte(CH_DOLLAR, 1'b1);
        // escaped star, then a backslash left dangling
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_STAR, 1'b0);
        send_byte(CH_BSLASH, 1'b1);
        // negated set closed right away
        send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_BANG, 1'b0);
        send_byte(CH_RBRACK, 1'b1);
        // empty set, then silence to the end
        send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_RBRACK, 1'b0);
        send_byte(8'h78, 1'b1);
        // open bracket as the last byte
        send_byte(CH_LBRACK, 1'b1);
        // negated set left open
        send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_BANG, 1'b0);
        send_byte(8'h61, 1'b1);

        // random patterns, with two long receiver holds along the way
        while (bytes_sent < N_RANDOM_BYTES + 25) begin
            if ((holds_done == 0 && bytes_sent >= 500) ||
                (holds_done == 1 && bytes_sent >= 1300)) begin
                hold_req = 1'b1;
                holds_done++;
            end
            send_random_pattern();
        end
        s_axis_tvalid <= 1'b0;

        // drain: let the pending count take in the last accepted word first
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
